### src/bscd_pkg.sv
// Package for the button sequence code detector.
// Shared types, button codes, register indexes and reset values; no dependencies.
package bscd_pkg;

  localparam int unsigned MAX_SEQUENCE = 16;

  localparam int unsigned BUTTON_CODE_W = 3;
  localparam int unsigned FOUND_DATA_W  = 16;
  localparam int unsigned PROGRESS_W    = 5;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned HELD_W        = 4;

  localparam logic [BUTTON_CODE_W-1:0] BTN_NONE  = 3'd0;
  localparam logic [BUTTON_CODE_W-1:0] BTN_A     = 3'd1;
  localparam logic [BUTTON_CODE_W-1:0] BTN_B     = 3'd2;
  localparam logic [BUTTON_CODE_W-1:0] BTN_X     = 3'd3;
  localparam logic [BUTTON_CODE_W-1:0] BTN_Y     = 3'd4;
  localparam logic [BUTTON_CODE_W-1:0] BTN_MULTI = 3'd5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SEQUENCE_CODES  = 2'd0,
    REG_SEQUENCE_LENGTH = 2'd1,
    REG_IDLE_TIMEOUT    = 2'd2,
    REG_FOUND_VALUE     = 2'd3
  } cfg_reg_t;

  localparam logic [31:0] SEQUENCE_CODES_RST  = 32'd934992;
  localparam logic [4:0]  SEQUENCE_LENGTH_RST = 5'd10;
  localparam logic [15:0] IDLE_TIMEOUT_RST    = 16'd1000;
  localparam logic [15:0] FOUND_VALUE_RST     = 16'd1;

  typedef struct packed {
    logic [31:0] sequence_codes;
    logic [4:0]  sequence_length;
    logic [15:0] idle_timeout;
    logic [15:0] found_value;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic [BUTTON_CODE_W-1:0] button_code;
  } item_t;

endpackage

### src/bscd_in_if.sv
// Input channel: one sampled button code per transaction.
// Depends on bscd_pkg.
interface bscd_in_if;
  import bscd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [BUTTON_CODE_W-1:0] button_code;

  modport source (output valid, output button_code, input ready);
  modport sink   (input valid, input button_code, output ready);
endinterface

### src/bscd_out_if.sv
// Result channel: found flag, found value and progress per transaction.
// Depends on bscd_pkg.
interface bscd_out_if;
  import bscd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [FOUND_DATA_W-1:0] found_data;
  logic [PROGRESS_W-1:0]   progress;

  modport source (output valid, output found, output found_data, output progress, input ready);
  modport sink   (input valid, input found, input found_data, input progress, output ready);
endinterface

### src/bscd_cfg_regs.sv
// Configuration register file of the button sequence code detector.
// Depends on bscd_pkg.
module bscd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [bscd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bscd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bscd_pkg::cfg_t                     cfg
);
  import bscd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sequence_codes  <= SEQUENCE_CODES_RST;
      cfg.sequence_length <= SEQUENCE_LENGTH_RST;
      cfg.idle_timeout    <= IDLE_TIMEOUT_RST;
      cfg.found_value     <= FOUND_VALUE_RST;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEQUENCE_CODES:  cfg.sequence_codes  <= cfg_data;
        REG_SEQUENCE_LENGTH: cfg.sequence_length <= cfg_data[4:0];
        REG_IDLE_TIMEOUT:    cfg.idle_timeout    <= cfg_data[15:0];
        REG_FOUND_VALUE:     cfg.found_value     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end
endmodule

### src/bscd_in_stage.sv
// Input register stage: captures one button code transaction.
// Depends on bscd_pkg and bscd_in_if.
module bscd_in_stage (
  input  logic           clk,
  input  logic           rst,
  bscd_in_if.sink        buttons,
  input  logic           advance,
  output bscd_pkg::item_t item
);
  import bscd_pkg::*;

  assign buttons.ready = !item.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (buttons.ready) begin
      item.valid <= buttons.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (buttons.valid && buttons.ready) begin
      item.button_code <= buttons.button_code;
    end
  end
endmodule

### src/bscd_core.sv
// Match state, hold/idle tracking and result register.
// Depends on bscd_pkg and bscd_out_if.
module bscd_core #(
  parameter int unsigned MAX_SEQUENCE = bscd_pkg::MAX_SEQUENCE
) (
  input  logic            clk,
  input  logic            rst,
  input  bscd_pkg::cfg_t  cfg,
  input  bscd_pkg::item_t item,
  output logic            advance,
  bscd_out_if.source      result
);
  import bscd_pkg::*;

  logic [PROGRESS_W-1:0] match_index, match_index_next;
  logic [HELD_W-1:0]     held_flags, held_flags_next;
  logic [15:0]           idle_counter, idle_counter_next;
  logic                  found_next;

  logic [1:0]            entry;
  logic [HELD_W-1:0]     bit_sel;
  logic [3:0]            pos;
  logic [1:0]            want;
  logic [PROGRESS_W-1:0] step;
  logic [PROGRESS_W-1:0] eff_len;
  logic [15:0]           idle_base;

  assign advance = item.valid && (!result.valid || result.ready);

  always_comb begin
    if (cfg.sequence_length == '0) begin
      eff_len = PROGRESS_W'(1);
    end else if (cfg.sequence_length > PROGRESS_W'(MAX_SEQUENCE)) begin
      eff_len = PROGRESS_W'(MAX_SEQUENCE);
    end else begin
      eff_len = cfg.sequence_length;
    end
  end

  always_comb begin
    entry     = 2'(item.button_code - BTN_A);
    bit_sel   = HELD_W'(1) << entry;
    pos       = match_index[3:0];
    want      = cfg.sequence_codes[{pos, 1'b0} +: 2];
    step      = match_index + PROGRESS_W'(1);
    idle_base = (idle_counter == '0) ? cfg.idle_timeout : idle_counter;

    match_index_next  = match_index;
    held_flags_next   = held_flags;
    idle_counter_next = idle_counter;
    found_next        = 1'b0;

    case (item.button_code)
      BTN_NONE: begin
        if (idle_counter == '0) begin
          match_index_next = '0;
        end
        held_flags_next   = '0;
        idle_counter_next = idle_base - 16'd1;
      end
      BTN_A, BTN_B, BTN_X, BTN_Y: begin
        if ((held_flags & bit_sel) == '0) begin
          if (entry == want) begin
            if (step >= eff_len) begin
              found_next       = 1'b1;
              match_index_next = '0;
            end else begin
              match_index_next = step;
            end
          end else begin
            match_index_next = '0;
          end
        end
        held_flags_next   = found_next ? '0 : bit_sel;
        idle_counter_next = cfg.idle_timeout;
      end
      default: begin
        match_index_next  = '0;
        held_flags_next   = '0;
        idle_counter_next = cfg.idle_timeout;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_index  <= '0;
      held_flags   <= '0;
      idle_counter <= IDLE_TIMEOUT_RST;
      result.valid <= 1'b0;
    end else begin
      if (advance) begin
        match_index  <= match_index_next;
        held_flags   <= held_flags_next;
        idle_counter <= idle_counter_next;
      end
      if (!result.valid || result.ready) begin
        result.valid <= item.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.found      <= found_next;
      result.found_data <= found_next ? cfg.found_value : '0;
      result.progress   <= match_index_next;
    end
  end
endmodule

### src/button_sequence_code_detector.sv
// Button sequence code detector. Each transaction on buttons carries one sampled button
// code; every one yields exactly one transaction on result with found, found_data and
// progress. Throughput is one transaction per clock; codes pass the input register, then the
// match/hold/idle update into the result register. While the result sink stalls, the input
// register takes at most one more code and then holds buttons.ready low. Configuration
// is written through cfg_write_en/cfg_index/cfg_data while no transaction is in flight.
// Depends on bscd_pkg, bscd_in_if, bscd_out_if, bscd_cfg_regs, bscd_in_stage, bscd_core.
module button_sequence_code_detector #(
  parameter int unsigned MAX_SEQUENCE = bscd_pkg::MAX_SEQUENCE
) (
  input  logic                             clk,
  input  logic                             rst,
  bscd_in_if.sink                          buttons,
  bscd_out_if.source                       result,
  input  logic                             cfg_write_en,
  input  logic [bscd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bscd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bscd_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  advance;

  bscd_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  bscd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .buttons (buttons),
    .advance (advance),
    .item    (item)
  );

  bscd_core #(
    .MAX_SEQUENCE (MAX_SEQUENCE)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  a_found_clears_progress: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.found) |-> (result.progress == '0))
    else $error("found with nonzero progress");

  a_no_data_without_found: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.found) |-> (result.found_data == '0))
    else $error("found_data set without found");

  a_progress_bounded: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.progress < PROGRESS_W'(MAX_SEQUENCE)))
    else $error("progress out of range");

  a_accept_when_drained: assert property (@(posedge clk) disable iff (rst)
    (result.ready && $past(result.ready) && !rst && !$past(rst)) |-> buttons.ready)
    else $error("input stalled while result sink is ready");
endmodule
